// File: rtl/dsa_pkg.sv
// shared types and constants of the descriptor slot allocator
package dsa_pkg;

    // fixed field widths
    localparam int ADDR_W     = 64;
    localparam int STRIDE_W   = 13;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_IDX_W  = 2;

    // tdata widths of both streams, padded to whole bytes
    localparam int S_DATA_W = ADDR_W;
    localparam int M_DATA_W = ((SLOT_OUT_W + 2 * ADDR_W + 7) / 8) * 8;

    // divider runs one quotient bit per step
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd2;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC  = 3'd0,
        ST_REUSE  = 3'd1,
        ST_UNCONF = 3'd2,
        ST_FREED  = 3'd3,
        ST_BAD    = 3'd4,
        ST_STICKY = 3'd5
    } status_t;

    // commands from the sequencer to the slot pool
    typedef struct packed {
        logic clear;
        logic scan_start;
        logic release_slot;
    } pool_cmd_t;

    // status from the slot pool back to the sequencer
    typedef struct packed {
        logic done;
        logic found;
        logic sticky_valid;
    } pool_stat_t;

endpackage

// File: rtl/dsa_divider.sv
// iterative restoring divider, one quotient bit per cycle
module dsa_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dsa_pkg::ADDR_W-1:0]    dividend,
    input  logic [dsa_pkg::STRIDE_W-1:0]  divisor,
    output logic                          done,
    output logic [dsa_pkg::ADDR_W-1:0]    quotient,
    output logic [dsa_pkg::STRIDE_W-1:0]  remainder
);
    import dsa_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0]     quo_reg, quo_next;
    logic [STRIDE_W-1:0]   rem_reg, rem_next;
    logic [STRIDE_W-1:0]   dvs_reg, dvs_next;
    logic [STRIDE_W:0]     partial;
    logic [STRIDE_W:0]     diff;
    logic                  ge;

    // one shift-subtract step
    assign partial = {rem_reg, quo_reg[ADDR_W-1]};
    assign ge      = partial >= {1'b0, dvs_reg};
    assign diff    = partial - {1'b0, dvs_reg};

    // step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[ADDR_W-2:0], ge};
            rem_next = ge ? diff[STRIDE_W-1:0] : partial[STRIDE_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/dsa_slot_pool.sv
// used bitmap, sticky slot and lowest-free scan
module dsa_slot_pool #(
    parameter int SLOT_COUNT = 10,
    parameter int SLOT_W     = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dsa_pkg::pool_cmd_t   cmd,
    input  logic [SLOT_W-1:0]    release_idx,
    output dsa_pkg::pool_stat_t  stat,
    output logic [SLOT_W-1:0]    chosen,
    output logic [SLOT_W-1:0]    sticky_slot
);
    import dsa_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic                  scan_reg, scan_next;
    logic [SLOT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     chosen_reg, chosen_next;
    logic                  sticky_valid_reg, sticky_valid_next;
    logic [SLOT_W-1:0]     sticky_reg, sticky_next;
    logic [SLOT_W-1:0]     pick;

    // scan one bitmap entry per cycle while no command is given, then claim the slot
    always_comb begin
        used_next         = used_reg;
        scan_next         = scan_reg;
        scan_idx_next     = scan_idx_reg;
        done_next         = 1'b0;
        found_next        = found_reg;
        chosen_next       = chosen_reg;
        sticky_valid_next = sticky_valid_reg;
        sticky_next       = sticky_reg;
        pick              = '0;
        if (cmd.clear) begin
            used_next         = '0;
            sticky_valid_next = 1'b0;
            sticky_next       = '0;
            scan_next         = 1'b0;
        end else if (cmd.scan_start) begin
            scan_next     = 1'b1;
            scan_idx_next = '0;
        end else if (cmd.release_slot) begin
            used_next[release_idx] = 1'b0;
        end else if (scan_reg) begin
            if (!used_reg[scan_idx_reg] || scan_idx_reg == LAST_IDX) begin
                // free entry found, or pool full: fall back to sticky or slot zero
                if (!used_reg[scan_idx_reg]) begin
                    pick       = scan_idx_reg;
                    found_next = 1'b1;
                end else begin
                    pick       = sticky_valid_reg ? sticky_reg : '0;
                    found_next = 1'b0;
                end
                used_next[pick] = 1'b1;
                chosen_next     = pick;
                if (!sticky_valid_reg) begin
                    sticky_valid_next = 1'b1;
                    sticky_next       = pick;
                end
                scan_next = 1'b0;
                done_next = 1'b1;
            end else begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end
    end

    // pool state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg         <= '0;
            scan_reg         <= 1'b0;
            scan_idx_reg     <= '0;
            done_reg         <= 1'b0;
            found_reg        <= 1'b0;
            chosen_reg       <= '0;
            sticky_valid_reg <= 1'b0;
            sticky_reg       <= '0;
        end else begin
            used_reg         <= used_next;
            scan_reg         <= scan_next;
            scan_idx_reg     <= scan_idx_next;
            done_reg         <= done_next;
            found_reg        <= found_next;
            chosen_reg       <= chosen_next;
            sticky_valid_reg <= sticky_valid_next;
            sticky_reg       <= sticky_next;
        end
    end

    assign stat.done         = done_reg;
    assign stat.found        = found_reg;
    assign stat.sticky_valid = sticky_valid_reg;
    assign chosen            = chosen_reg;
    assign sticky_slot       = sticky_reg;

endmodule

// File: rtl/descriptor_slot_allocator.sv
// top level: request sequencer, handle arithmetic and result register
//
//  channel  | valid/ready          | payload
//  ---------+----------------------+-----------------------------------------------
//  request  | s_tvalid / s_tready  | s_tuser: action; s_tdata: free_handle
//  result   | m_tvalid / m_tready  | m_tuser: status; m_tdata: slot, cpu, gpu handle
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  allocate runs the bitmap scan, one entry per cycle while no config write
//  clears the pool, then a multiply state and an add state
//  free runs the 64-step divider on handle minus base, then a check state
//  an unconfigured pool or a handle that is zero or below base goes to the result state directly
//  reset clears the pool at once; a config write to index 0, 1 or 2 clears it
//  the result waits in an output register, so a stalled result does not stop
//  the next request from being taken
module descriptor_slot_allocator #(
    parameter int SLOT_COUNT = 10,
    parameter int POOL_FIRST = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dsa_pkg::S_DATA_W-1:0]    s_tdata,   // [63:0] free_handle
    input  logic                            s_tuser,   // [0] action
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dsa_pkg::M_DATA_W-1:0]    m_tdata,   // [3:0] slot, [67:4] cpu_handle,
                                                       // [131:68] gpu_handle, rest zero
    output logic [dsa_pkg::STATUS_W-1:0]    m_tuser,   // [2:0] status
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsa_pkg::ADDR_W-1:0]      cfg_data
);
    import dsa_pkg::*;

    localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POOL_END = POOL_FIRST + SLOT_COUNT;
    localparam int IDX_W    = $clog2(POOL_END + 1);
    localparam int MUL_W    = IDX_W + STRIDE_W;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_ADD    = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;

    logic [ADDR_W-1:0]     cpu_base_reg, cpu_base_next;
    logic [ADDR_W-1:0]     gpu_base_reg, gpu_base_next;
    logic [STRIDE_W-1:0]   stride_reg, stride_next;

    logic [ADDR_W-1:0]     off_reg, off_next;
    status_t               res_status_reg, res_status_next;
    logic [SLOT_OUT_W-1:0] res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]     res_cpu_reg, res_cpu_next;
    logic [ADDR_W-1:0]     res_gpu_reg, res_gpu_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic                  cfg_hit;
    logic [ADDR_W:0]       delta_wide;
    logic [IDX_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_p;
    logic [IDX_W-1:0]      q_lo;
    logic                  q_in_pool;
    logic [SLOT_W-1:0]     free_idx;

    pool_cmd_t             pool_cmd;
    pool_stat_t            pool_stat;
    logic [SLOT_W-1:0]     pool_chosen;
    logic [SLOT_W-1:0]     pool_sticky;

    logic                  div_start;
    logic                  div_done;
    logic [ADDR_W-1:0]     div_quo;
    logic [STRIDE_W-1:0]   div_rem;

    dsa_slot_pool #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_pool (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (pool_cmd),
        .release_idx (free_idx),
        .stat        (pool_stat),
        .chosen      (pool_chosen),
        .sticky_slot (pool_sticky)
    );

    dsa_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (delta_wide[ADDR_W-1:0]),
        .divisor   (stride_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // handle offset; the borrow bit flags a handle below base
    assign delta_wide = {1'b0, s_tdata} - {1'b0, cpu_base_reg};

    // descriptor index times stride
    assign mul_a = IDX_W'(POOL_FIRST) + IDX_W'(pool_chosen);
    assign mul_p = MUL_W'(mul_a) * MUL_W'(stride_reg);

    // resolved index must lie inside the pool window
    assign q_lo      = div_quo[IDX_W-1:0];
    assign q_in_pool = (div_quo[ADDR_W-1:IDX_W] == '0)
                       && (q_lo >= IDX_W'(POOL_FIRST))
                       && (q_lo < IDX_W'(POOL_END));
    assign free_idx  = SLOT_W'(q_lo - IDX_W'(POOL_FIRST));

    // configuration writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == CFG_CPU_BASE
                       || cfg_index == CFG_GPU_BASE || cfg_index == CFG_STRIDE);

    always_comb begin
        cpu_base_next = cpu_base_reg;
        gpu_base_next = gpu_base_reg;
        stride_next   = stride_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CPU_BASE: cpu_base_next = cfg_data;
                CFG_GPU_BASE: gpu_base_next = cfg_data;
                CFG_STRIDE:   stride_next   = cfg_data[STRIDE_W-1:0];
                default:      ;
            endcase
        end
    end

    // request sequencer
    always_comb begin
        state_next      = state_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_cpu_next    = res_cpu_reg;
        res_gpu_next    = res_gpu_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        pool_cmd        = '{clear: cfg_hit, scan_start: 1'b0, release_slot: 1'b0};
        div_start       = 1'b0;

        // output register drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_slot_next = '0;
                    res_cpu_next  = '0;
                    res_gpu_next  = '0;
                    if (stride_reg == '0) begin
                        res_status_next = ST_UNCONF;
                        state_next      = S_RESULT;
                    end else if (s_tuser == ACT_ALLOC) begin
                        pool_cmd.scan_start = 1'b1;
                        state_next          = S_SCAN;
                    end else if (s_tdata == '0 || delta_wide[ADDR_W]) begin
                        res_status_next = ST_BAD;
                        state_next      = S_RESULT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_SCAN: begin
                if (pool_stat.done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                off_next        = ADDR_W'(mul_p);
                res_status_next = pool_stat.found ? ST_ALLOC : ST_REUSE;
                res_slot_next   = SLOT_OUT_W'(pool_chosen);
                state_next      = S_ADD;
            end
            S_ADD: begin
                res_cpu_next = cpu_base_reg + off_reg;
                res_gpu_next = gpu_base_reg + off_reg;
                state_next   = S_RESULT;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (div_rem != '0 || !q_in_pool) begin
                    res_status_next = ST_BAD;
                end else if (pool_stat.sticky_valid && free_idx == pool_sticky) begin
                    res_status_next = ST_STICKY;
                    res_slot_next   = SLOT_OUT_W'(free_idx);
                end else begin
                    pool_cmd.release_slot = 1'b1;
                    res_status_next       = ST_FREED;
                    res_slot_next         = SLOT_OUT_W'(free_idx);
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = M_DATA_W'({res_gpu_reg, res_cpu_reg, res_slot_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
            stride_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            cpu_base_reg <= cpu_base_next;
            gpu_base_reg <= gpu_base_next;
            stride_reg   <= stride_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_cpu_reg    <= res_cpu_next;
        res_gpu_reg    <= res_gpu_next;
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;

endmodule
